// ===== src/frame_animation_sequencer_core_assert.svh =====
// Assertion helpers used by the sequencer RTL.
`ifndef FRAME_ANIMATION_SEQUENCER_CORE_ASSERT_SVH
`define FRAME_ANIMATION_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define FAS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FAS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fas_pkg.sv =====
package fas_pkg;

  localparam int MAX_FRAMES  = 16;
  localparam int DELAY_BITS  = 16;
  localparam int FRAME_BITS  = $clog2(MAX_FRAMES);
  localparam int FCOUNT_BITS = 5;
  localparam int MODE_BITS   = 2;
  localparam int CMD_BITS    = 3;

  localparam logic [CMD_BITS-1:0] CMD_TICK  = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_PLAY  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_LOOP  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_STOP  = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_PAUSE = 3'd4;
  localparam logic [CMD_BITS-1:0] CMD_WRITE = 3'd5;

  localparam logic [MODE_BITS-1:0] MODE_STOPPED = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_ONCE    = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_LOOP    = 2'd2;

  typedef struct packed {
    logic [3:0]  current_frame;
    logic [1:0]  play_mode;
    logic [15:0] delay_left;
  } res_t;

endpackage

// ===== src/fas_if.sv =====
interface fas_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  frame_index;
  logic [15:0] delay_value;

  modport source (output valid, output command, output frame_index,
                  output delay_value, input ready);
  modport sink (input valid, input command, input frame_index,
                input delay_value, output ready);
endinterface

interface fas_res_if;
  logic        valid;
  logic        ready;
  logic [3:0]  current_frame;
  logic [1:0]  play_mode;
  logic [15:0] delay_left;

  modport source (output valid, output current_frame, output play_mode,
                  output delay_left, input ready);
  modport sink (input valid, input current_frame, input play_mode,
                input delay_left, output ready);
endinterface

// ===== src/fas_ram.sv =====
module fas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/fas_seq.sv =====
`include "frame_animation_sequencer_core_assert.svh"

module fas_seq import fas_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  fas_cmd_if.sink                cmd,
  input  logic [FCOUNT_BITS-1:0] frame_count,
  output logic                   res_valid,
  input  logic                   res_take,
  output res_t                   res
);

  logic [FRAME_BITS-1:0] frame_pos, frame_pos_next;
  logic [MODE_BITS-1:0]  mode, mode_next;
  logic [DELAY_BITS-1:0] delay_count, delay_next;
  logic [DELAY_BITS-1:0] delay_base, ram_val;
  logic [FRAME_BITS-1:0] last_frame;
  logic [MAX_FRAMES-1:0] valid_bits;
  logic                  pend, rd_valid, s1_valid, in_fire;
  logic                  rd_req, wr_req;
  logic [FRAME_BITS-1:0] raddr, waddr;
  logic [DELAY_BITS-1:0] wdata, rdata;

  assign in_fire   = cmd.valid & cmd.ready;
  assign cmd.ready = ~s1_valid | res_take;
  assign res_valid = s1_valid;

  // entries never written read as one
  assign ram_val    = rd_valid ? rdata : DELAY_BITS'(1);
  // a reload issued by the previous item lands from the table this cycle
  assign delay_base = pend ? ram_val : delay_count;

  // the state itself is the result of the item held in stage one
  assign res.current_frame = frame_pos;
  assign res.play_mode     = mode;
  assign res.delay_left    = delay_base;

  always_comb begin
    if (frame_count == '0) begin
      last_frame = '0;
    end else if (frame_count > FCOUNT_BITS'(MAX_FRAMES)) begin
      last_frame = FRAME_BITS'(MAX_FRAMES - 1);
    end else begin
      last_frame = FRAME_BITS'(frame_count - FCOUNT_BITS'(1));
    end
  end

  always_comb begin
    frame_pos_next = frame_pos;
    mode_next      = mode;
    delay_next     = delay_base;
    rd_req         = 1'b0;
    raddr          = '0;
    wr_req         = 1'b0;
    waddr          = cmd.frame_index;
    wdata          = (cmd.delay_value == '0) ? DELAY_BITS'(1) : cmd.delay_value;
    case (cmd.command)
      CMD_TICK: begin
        if (mode != MODE_STOPPED) begin
          if (delay_base != '0) begin
            delay_next = delay_base - DELAY_BITS'(1);
          end else if (frame_pos >= last_frame) begin
            if (mode == MODE_LOOP) begin
              frame_pos_next = '0;
              rd_req         = 1'b1;
            end else begin
              mode_next = MODE_STOPPED;
            end
          end else begin
            frame_pos_next = frame_pos + FRAME_BITS'(1);
            raddr          = frame_pos + FRAME_BITS'(1);
            rd_req         = 1'b1;
          end
        end
      end
      CMD_PLAY: begin
        mode_next      = MODE_ONCE;
        frame_pos_next = '0;
        rd_req         = 1'b1;
      end
      CMD_LOOP: begin
        mode_next      = MODE_LOOP;
        frame_pos_next = '0;
      end
      CMD_STOP: begin
        mode_next      = MODE_STOPPED;
        frame_pos_next = '0;
      end
      CMD_PAUSE: begin
        mode_next = MODE_STOPPED;
      end
      CMD_WRITE: begin
        wr_req = ({1'b0, cmd.frame_index} < (FRAME_BITS+1)'(MAX_FRAMES));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos   <= '0;
      mode        <= MODE_STOPPED;
      delay_count <= '0;
      pend        <= 1'b0;
      valid_bits  <= '0;
      s1_valid    <= 1'b0;
    end else begin
      if (in_fire) begin
        frame_pos   <= frame_pos_next;
        mode        <= mode_next;
        delay_count <= delay_next;
        pend        <= rd_req;
        if (wr_req) begin
          valid_bits[waddr] <= 1'b1;
        end
      end else if (pend) begin
        delay_count <= ram_val;
        pend        <= 1'b0;
      end
      if (in_fire) begin
        s1_valid <= 1'b1;
      end else if (res_take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && rd_req) begin
      rd_valid <= valid_bits[raddr];
    end
  end

  fas_ram #(
    .WIDTH (DELAY_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_table (
    .clk   (clk),
    .we    (in_fire & wr_req),
    .waddr (waddr),
    .wdata (wdata),
    .re    (in_fire & rd_req),
    .raddr (raddr),
    .rdata (rdata)
  );

  `FAS_ASSERT_IMPL(a_reload_nonzero, clk, rst, pend, ram_val != '0, "reload delay is zero")
  `FAS_ASSERT_IMPL(a_pend_has_result, clk, rst, pend, s1_valid, "reload with no item held")
  `FAS_ASSERT_NEXT(a_stop_rewinds, clk, rst, in_fire && cmd.command == CMD_STOP, frame_pos == '0 && mode == MODE_STOPPED, "stop did not rewind")

endmodule

// ===== src/fas_res_stage.sv =====
module fas_res_stage import fas_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_take,
  input  res_t     in_data,
  fas_res_if.source res
);

  logic out_valid;
  res_t out_data;

  assign in_take           = ~out_valid | res.ready;
  assign res.valid         = out_valid;
  assign res.current_frame = out_data.current_frame;
  assign res.play_mode     = out_data.play_mode;
  assign res.delay_left    = out_data.delay_left;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_valid && in_take) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_take) begin
      out_data <= in_data;
    end
  end

endmodule

// ===== src/frame_animation_sequencer_core.sv =====
// Sprite frame sequencer: each command item (tick, play, loop, stop, pause,
// write delay) yields one result item with the frame shown, the play mode and
// the ticks left. One item is taken every clock cycle while the result path
// is not held back by res.ready; a result passes the state registers, which
// load at the accepting edge, and then the output register. The per-frame
// delay table sits in a 16-entry RAM with a registered read port; a reload
// read by one item is forwarded straight into the next, so no stall arises.
// Table entries read as one until written, so no clearing pass follows reset.
// frame_count may be written only while no item is in flight.
module frame_animation_sequencer_core import fas_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  fas_cmd_if.sink                cmd,
  fas_res_if.source              res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [FCOUNT_BITS-1:0] cfg_data
);

  logic [FCOUNT_BITS-1:0] frame_count;
  logic                   s1_valid, s1_take;
  res_t                   s1_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= FCOUNT_BITS'(1);
    end else if (cfg_valid) begin
      frame_count <= cfg_data;
    end
  end

  fas_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .frame_count (frame_count),
    .res_valid   (s1_valid),
    .res_take    (s1_take),
    .res         (s1_data)
  );

  fas_res_stage u_res (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s1_valid),
    .in_take  (s1_take),
    .in_data  (s1_data),
    .res      (res)
  );

endmodule
